[rtl/ulav_pkg.sv]
// Shared types and constants for the UTF-8 Latin alphanumeric checker.
package ulav_pkg;

    // Byte classes
    localparam logic [7:0] LEAD2_MASK    = 8'b1110_0000;
    localparam logic [7:0] LEAD2_CODE    = 8'b1100_0000;
    localparam logic [7:0] CONT_MASK     = 8'b1100_0000;
    localparam logic [7:0] CONT_CODE     = 8'b1000_0000;
    localparam logic [4:0] LEAD_PAYLOAD  = 5'b1_1111;
    localparam logic [5:0] CONT_PAYLOAD  = 6'b11_1111;

    // Accepted code point ranges
    localparam logic [10:0] LAT1_A_LO = 11'h0C0;
    localparam logic [10:0] LAT1_A_HI = 11'h0D6;
    localparam logic [10:0] LAT1_B_LO = 11'h0D8;
    localparam logic [10:0] LAT1_B_HI = 11'h0F6;
    localparam logic [10:0] LAT1_C_LO = 11'h0F8;
    localparam logic [10:0] LAT1_C_HI = 11'h0FF;
    localparam logic [10:0] LATA_LO   = 11'h100;
    localparam logic [10:0] LATA_HI   = 11'h17F;

    // Text scan state carried from byte to byte
    typedef struct packed {
        logic       awaiting;
        logic [4:0] lead_payload;
        logic       failed;
    } scan_state_t;

endpackage

[rtl/ulav_char_check.sv]
// Per-byte decode and character check; produces the next scan state.
module ulav_char_check
(
    input  logic [7:0]           text_byte,
    input  logic                 final_byte,
    input  ulav_pkg::scan_state_t state,
    output ulav_pkg::scan_state_t state_next,
    output logic                 all_alnum
);
    import ulav_pkg::*;

    logic [10:0] code_point;
    logic        code_ok;
    logic        ascii_ok;
    logic        is_cont;
    logic        is_lead;
    scan_state_t step;

    // Decode the two-byte code point and classify the byte
    assign code_point = {state.lead_payload, text_byte[5:0] & CONT_PAYLOAD};
    assign is_cont    = (text_byte & CONT_MASK) == CONT_CODE;
    assign is_lead    = (text_byte & LEAD2_MASK) == LEAD2_CODE;

    assign code_ok = (code_point >= LAT1_A_LO && code_point <= LAT1_A_HI) ||
                     (code_point >= LAT1_B_LO && code_point <= LAT1_B_HI) ||
                     (code_point >= LAT1_C_LO && code_point <= LAT1_C_HI) ||
                     (code_point >= LATA_LO   && code_point <= LATA_HI);

    assign ascii_ok = (text_byte >= 8'h30 && text_byte <= 8'h39) ||
                      (text_byte >= 8'h41 && text_byte <= 8'h5A) ||
                      (text_byte >= 8'h61 && text_byte <= 8'h7A);

    // Advance the scan state by one byte
    always_comb
    begin
        step = state;
        priority if (state.awaiting)
        begin
            step.awaiting     = 1'b0;
            step.lead_payload = '0;
            if (!is_cont || !code_ok)
            begin
                step.failed = 1'b1;
            end
        end
        else if (!text_byte[7])
        begin
            if (!ascii_ok)
            begin
                step.failed = 1'b1;
            end
        end
        else if (is_lead)
        begin
            step.awaiting     = 1'b1;
            step.lead_payload = text_byte[4:0] & LEAD_PAYLOAD;
        end
        else
        begin
            step.failed = 1'b1;
        end
    end

    // Report on the last byte and clear the state for the next text
    assign all_alnum  = !(step.failed || step.awaiting);
    assign state_next = final_byte ? scan_state_t'('0) : step;

endmodule

[rtl/utf8_latin_alnum_validator_unit.sv]
// Top level: input register, scan state, check logic and result register.
// A final byte is held in the input register, then its result is written to the result register that drives m_tvalid.
// Throughput: one byte per cycle; the check is one level of logic between
// the input register and the result register, and a byte that ends a text
// stalls only while the result register is full and not being taken.
// Reset: rst_n clears the scan state and both valid flags at once.
module utf8_latin_alnum_validator_unit
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] text_byte
    input  logic       s_tlast,   // final_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] all_alnum, [7:1] zero
);
    import ulav_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    scan_state_t state_reg;
    scan_state_t state_next;
    logic        out_valid_reg;
    logic        out_alnum_reg;
    logic        alnum_next;
    logic        consume;

    // Consume the held byte unless it ends a text and the result slot is full
    assign consume  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || consume;

    ulav_char_check u_check
    (
        .text_byte  (in_byte_reg),
        .final_byte (in_last_reg),
        .state      (state_reg),
        .state_next (state_next),
        .all_alnum  (alnum_next)
    );

    // Hold the input request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Advance scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (consume)
        begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (consume && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume && in_last_reg)
        begin
            out_alnum_reg <= alnum_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_alnum_reg};

    // A result appears only after a final byte was consumed
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(consume && in_last_reg))
        else $error("result without final byte");

    // Payload is only kept while a continuation byte is due
    a_payload_awaiting: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.lead_payload != 5'd0) |-> state_reg.awaiting)
        else $error("lead payload without pending continuation");

    // State is cleared after each text
    a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && in_last_reg) |=> (state_reg == scan_state_t'('0)))
        else $error("scan state not cleared after final byte");

    // Never drop a pending result when a new final byte is consumed
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && in_last_reg) |-> (!out_valid_reg || m_tready))
        else $error("result overwritten");

endmodule

[tb/testbench.sv]
// Stream testbench for the UTF-8 Latin alphanumeric checker: random bursts, stalls, scoreboard.
`timescale 1ns / 1ps

module testbench;

    // Byte classes and accepted code point bounds
    localparam logic [7:0]  LEAD2_MASK = 8'hE0;
    localparam logic [7:0]  LEAD2_CODE = 8'hC0;
    localparam logic [7:0]  CONT_MASK  = 8'hC0;
    localparam logic [7:0]  CONT_CODE  = 8'h80;
    localparam logic [7:0]  ASCII_TOP  = 8'h80;
    localparam logic [10:0] CP_A_LO    = 11'h0C0;
    localparam logic [10:0] CP_A_HI    = 11'h0D6;
    localparam logic [10:0] CP_B_LO    = 11'h0D8;
    localparam logic [10:0] CP_B_HI    = 11'h0F6;
    localparam logic [10:0] CP_C_LO    = 11'h0F8;
    localparam logic [10:0] CP_C_HI    = 11'h0FF;
    localparam logic [10:0] CP_EXT_LO  = 11'h100;
    localparam logic [10:0] CP_EXT_HI  = 11'h17F;

    localparam int RANDOM_BYTES = 830;
    localparam int HOLD_CYCLES  = 300;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } text_req_t;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;    // [7:0] text_byte
    logic       s_tlast;    // final_byte
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;    // [0] all_alnum, [7:1] zero

    text_req_t  text_req_q[$];
    logic       verdict_q[$];
    text_req_t  next_req;

    // Own copy of the scan state
    logic       scan_awaiting;
    logic [4:0] scan_lead;
    logic       scan_failed;

    int         mismatch_count;
    int         verdicts_checked;
    int         burst_left;
    int         gap_left;
    int         rx_cycle;
    logic       in_took;
    logic       hold_off;

    utf8_latin_alnum_validator_unit dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #3_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic logic is_ascii_alnum(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
               (b >= 8'h61 && b <= 8'h7A);
    endfunction

    function automatic logic is_latin_letter(input logic [10:0] cp);
        return (cp >= CP_A_LO && cp <= CP_A_HI) || (cp >= CP_B_LO && cp <= CP_B_HI) ||
               (cp >= CP_C_LO && cp <= CP_C_HI) || (cp >= CP_EXT_LO && cp <= CP_EXT_HI);
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    // Advance the scan state by one byte; give a verdict on the final byte
    task automatic scan_byte(input logic [7:0] b, input logic fin,
                             output logic produced, output logic verdict);
        produced = 1'b0;
        verdict  = 1'b0;
        if (scan_awaiting)
        begin
            scan_awaiting = 1'b0;
            if ((b & CONT_MASK) == CONT_CODE)
            begin
                if (!is_latin_letter({scan_lead, b[5:0]}))
                    scan_failed = 1'b1;
            end
            else
                scan_failed = 1'b1;
            scan_lead = '0;
        end
        else if (b < ASCII_TOP)
        begin
            if (!is_ascii_alnum(b))
                scan_failed = 1'b1;
        end
        else if ((b & LEAD2_MASK) == LEAD2_CODE)
        begin
            scan_awaiting = 1'b1;
            scan_lead     = b[4:0];
        end
        else
            scan_failed = 1'b1;

        if (fin)
        begin
            if (scan_awaiting)
                scan_failed = 1'b1;
            produced      = 1'b1;
            verdict       = !scan_failed;
            scan_awaiting = 1'b0;
            scan_lead     = '0;
            scan_failed   = 1'b0;
        end
    endtask

    task automatic push_byte(input logic [7:0] b, input logic fin);
        text_req_q.push_back('{text_byte: b, final_byte: fin});
    endtask

    task automatic push_code_point(input logic [10:0] cp, input logic fin);
        push_byte(LEAD2_CODE | {3'b000, cp[10:6]}, 1'b0);
        push_byte(CONT_CODE | {2'b00, cp[5:0]}, fin);
    endtask

    function automatic logic [10:0] random_letter();
        case ($urandom_range(0, 5))
            0:       return 11'($urandom_range(CP_A_LO, CP_A_HI));
            1:       return 11'($urandom_range(CP_B_LO, CP_B_HI));
            2:       return 11'($urandom_range(CP_C_LO, CP_C_HI));
            3:       return 11'($urandom_range(CP_EXT_LO, CP_EXT_HI));
            default:
            begin
                // Hit the range edges often
                case ($urandom_range(0, 7))
                    0:       return CP_A_LO;
                    1:       return CP_A_HI;
                    2:       return CP_B_LO;
                    3:       return CP_B_HI;
                    4:       return CP_C_LO;
                    5:       return CP_C_HI;
                    6:       return CP_EXT_LO;
                    default: return CP_EXT_HI;
                endcase
            end
        endcase
    endfunction

    function automatic logic [7:0] random_ascii_alnum();
        case ($urandom_range(0, 2))
            0:       return 8'($urandom_range(8'h30, 8'h39));
            1:       return 8'($urandom_range(8'h41, 8'h5A));
            default: return 8'($urandom_range(8'h61, 8'h7A));
        endcase
    endfunction

    // One random text: mostly well formed, sometimes with a broken character
    task automatic push_random_text();
        int   len;
        int   bad_pos;
        logic fin;
        len     = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
        bad_pos = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len - 1) : -1;
        for (int i = 0; i < len; i++)
        begin
            fin = (i == len - 1);
            if (i == bad_pos)
            begin
                case ($urandom_range(0, 4))
                    0: push_byte(8'($urandom_range(0, 255)), fin);
                    1: push_code_point(11'($urandom_range(0, 11'h7FF)), fin);
                    2: push_byte(LEAD2_CODE | 8'($urandom_range(0, 31)), fin);
                    3:
                    begin
                        push_byte(LEAD2_CODE | 8'($urandom_range(0, 31)), 1'b0);
                        push_byte(8'($urandom_range(0, 255)), fin);
                    end
                    default: push_byte(8'($urandom_range(8'h80, 8'hFF)), fin);
                endcase
            end
            else if ($urandom_range(0, 1) == 0)
                push_byte(random_ascii_alnum(), fin);
            else
                push_code_point(random_letter(), fin);
        end
    endtask

    // Stimulus and end of run
    initial
    begin
        rst_n = 1'b0;

        // Directed texts: range edges and each special case
        push_byte(8'h30, 1'b1);
        push_byte(8'h39, 1'b0); push_byte(8'h41, 1'b0); push_byte(8'h5A, 1'b0);
        push_byte(8'h61, 1'b0); push_byte(8'h7A, 1'b1);
        push_byte(8'h00, 1'b1);
        push_byte(8'h7F, 1'b1);
        push_code_point(CP_A_LO, 1'b0); push_code_point(CP_EXT_HI, 1'b1);
        push_code_point(11'h0D7, 1'b1);                 // multiplication sign
        push_code_point(11'h180, 1'b1);                 // just past Latin Extended-A
        push_byte(8'hC0, 1'b0); push_byte(8'h80, 1'b1); // overlong form
        push_byte(8'hC3, 1'b0); push_byte(8'h41, 1'b1); // bad continuation
        push_byte(8'h41, 1'b0); push_byte(8'hC3, 1'b1); // lead byte at the end
        push_byte(8'h80, 1'b1);                         // stray continuation
        push_byte(8'hE2, 1'b0); push_byte(8'hFF, 1'b1); // long-form lead, then FF
        push_byte(8'h20, 1'b0); push_byte(8'h41, 1'b1); // failure stays sticky
        push_code_point(CP_C_HI, 1'b1);

        while (text_req_q.size() < RANDOM_BYTES)
            push_random_text();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Drain stimulus, then expected verdicts
        while (text_req_q.size() != 0 || s_tvalid)
            @(posedge clk);
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Long receiver hold-off so the block fills and stalls its input
    initial
    begin
        hold_off = 1'b0;
        while (verdicts_checked < 30)
            @(posedge clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
    end

    // Driver: offer requests in bursts with random gaps
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tlast    <= 1'b0;
            burst_left <= 1;
            gap_left   <= 0;
        end
        else if (!s_tvalid || in_took)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end
            else if (text_req_q.size() != 0)
            begin
                next_req = text_req_q.pop_front();
                s_tdata  <= next_req.text_byte;
                s_tlast  <= next_req.final_byte;
                s_tvalid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver: stall on a rotating pattern
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_cycle <= 0;
        end
        else
        begin
            rx_cycle <= rx_cycle + 1;
            case ((rx_cycle / 64) % 4)
                0:       m_tready <= !hold_off;
                1:       m_tready <= !hold_off && ($urandom_range(0, 1) == 0);
                2:       m_tready <= !hold_off && (rx_cycle % 3 == 0);
                default: m_tready <= !hold_off && ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Monitor: check results, then predict from accepted requests
    always @(posedge clk or negedge rst_n)
    begin : monitor
        logic produced;
        logic verdict;
        logic want;
        if (!rst_n)
        begin
            in_took          <= 1'b0;
            scan_awaiting    = 1'b0;
            scan_lead        = '0;
            scan_failed      = 1'b0;
            mismatch_count   = 0;
            verdicts_checked = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (verdict_q.size() == 0)
                    report_mismatch($sformatf("unexpected result %02h", m_tdata));
                else
                begin
                    want = verdict_q.pop_front();
                    if (m_tdata[0] !== want)
                        report_mismatch($sformatf("all_alnum %b, expected %b",
                                                  m_tdata[0], want));
                    verdicts_checked++;
                end
            end
            in_took <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
            begin
                scan_byte(s_tdata, s_tlast, produced, verdict);
                if (produced)
                    verdict_q.push_back(verdict);
            end
        end
    end

endmodule
